>>> design/assert_macros.svh
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define HRL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked at every edge, reset included
`define HRL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> design/hrl_pkg.sv
`default_nettype none
package hrl_pkg;

    localparam int STORE_BYTES_DEF = 8192;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic [9:0] POS_START  = 10'd0;
    localparam logic [9:0] POS_DATA   = 10'd9;
    localparam logic [9:0] POS_LAST   = 10'd1022;
    localparam logic [9:0] POS_IGNORE = 10'd1023;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_COLON = 2'd1;
    localparam logic [1:0] ERR_HEX   = 2'd2;
    localparam logic [1:0] ERR_ADDR  = 2'd3;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [12:0] wr_addr;
        logic [7:0]  wr_data;
        logic [16:0] img_size;
        logic [1:0]  err;
        logic        last;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

>>> design/hrl_parser.sv
`default_nettype none
`include "assert_macros.svh"
module hrl_parser
    import hrl_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_last_char,
    output t_result         o_res_a,
    output logic            o_push_a,
    output t_result         o_res_b,
    output logic            o_push_b
);

    localparam logic [16:0] STORE_LIM = 17'(STORE_BYTES);

    logic [9:0]  r_pos,      n_pos;
    logic [7:0]  r_count,    n_count;
    logic [15:0] r_start,    n_start;
    logic [15:0] r_running,  n_running;
    logic [3:0]  r_high,     n_high;
    logic [15:0] r_best_start, n_best_start;
    logic [7:0]  r_best_count, n_best_count;
    logic [1:0]  r_first_error, n_first_error;

    t_hex        hx;
    logic [9:0]  k;
    logic        flag;
    logic [1:0]  flag_code;
    logic        emit;
    logic [16:0] img_size;
    logic [1:0]  sum_err;

    assign hx = hex_decode(i_char_in);
    assign k  = r_pos - POS_DATA;

    always_comb begin
        n_pos         = r_pos;
        n_count       = r_count;
        n_start       = r_start;
        n_running     = r_running;
        n_high        = r_high;
        n_best_start  = r_best_start;
        n_best_count  = r_best_count;
        n_first_error = r_first_error;
        flag          = 1'b0;
        flag_code     = ERR_NONE;
        emit          = 1'b0;
        if (i_accept) begin
            if (i_char_in == CH_NL) begin
                if (r_pos == POS_START && r_first_error == ERR_NONE) begin
                    n_first_error = ERR_COLON;
                end
                n_pos = POS_START;
            end else if (r_pos == POS_IGNORE) begin
                n_pos = r_pos;
            end else if (r_pos == POS_START) begin
                if (i_char_in == CH_COLON) begin
                    n_pos = 10'd1;
                end else begin
                    flag      = 1'b1;
                    flag_code = ERR_COLON;
                end
            end else if (r_pos < POS_DATA) begin
                if (!hx.ok) begin
                    flag      = 1'b1;
                    flag_code = ERR_HEX;
                end else begin
                    if (r_pos <= 10'd2) begin
                        n_count = {r_count[3:0], hx.val};
                    end else if (r_pos <= 10'd6) begin
                        n_start = {r_start[11:0], hx.val};
                    end
                    if (r_pos == 10'd8) begin
                        n_running = r_start;
                        if (r_count != 8'd0 && r_start >= r_best_start) begin
                            n_best_start = r_start;
                            n_best_count = r_count;
                        end
                    end
                    n_pos = r_pos + 10'd1;
                end
            end else if (k < {1'b0, r_count, 1'b0}) begin
                if (!hx.ok) begin
                    flag      = 1'b1;
                    flag_code = ERR_HEX;
                end else if (!k[0]) begin
                    n_high = hx.val;
                    n_pos  = r_pos + 10'd1;
                end else if (17'(r_running) >= STORE_LIM) begin
                    flag      = 1'b1;
                    flag_code = ERR_ADDR;
                end else begin
                    emit      = 1'b1;
                    n_running = r_running + 16'd1;
                    n_pos     = r_pos + 10'd1;
                end
            end else begin
                n_pos = (r_pos >= POS_LAST) ? POS_IGNORE : r_pos + 10'd1;
            end
            if (flag) begin
                if (r_first_error == ERR_NONE) begin
                    n_first_error = flag_code;
                end
                n_pos = POS_IGNORE;
            end
        end
        img_size = 17'(n_best_start) + 17'(n_best_count);
        sum_err  = n_first_error;
        if (i_accept && i_last_char) begin
            n_pos         = POS_START;
            n_count       = '0;
            n_start       = '0;
            n_running     = '0;
            n_high        = '0;
            n_best_start  = '0;
            n_best_count  = '0;
            n_first_error = ERR_NONE;
        end
    end

    always_comb begin
        o_push_a         = emit;
        o_res_a.kind     = KIND_WRITE;
        o_res_a.wr_addr  = r_running[12:0];
        o_res_a.wr_data  = {r_high, hx.val};
        o_res_a.img_size = '0;
        o_res_a.err      = ERR_NONE;
        o_res_a.last     = !i_last_char;
        o_push_b         = i_accept && i_last_char;
        o_res_b.kind     = KIND_SUMMARY;
        o_res_b.wr_addr  = '0;
        o_res_b.wr_data  = '0;
        o_res_b.img_size = img_size;
        o_res_b.err      = sum_err;
        o_res_b.last     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= POS_START;
            r_count       <= '0;
            r_start       <= '0;
            r_running     <= '0;
            r_high        <= '0;
            r_best_start  <= '0;
            r_best_count  <= '0;
            r_first_error <= ERR_NONE;
        end else begin
            r_pos         <= n_pos;
            r_count       <= n_count;
            r_start       <= n_start;
            r_running     <= n_running;
            r_high        <= n_high;
            r_best_start  <= n_best_start;
            r_best_count  <= n_best_count;
            r_first_error <= n_first_error;
        end
    end

    `HRL_ASSERT(a_eof_clears, i_accept && i_last_char |=> r_pos == POS_START && r_first_error == ERR_NONE && r_best_start == '0, "state not cleared after end of file")
    `HRL_ASSERT(a_err_sticky, r_first_error != ERR_NONE && !(i_accept && i_last_char) |=> r_first_error == $past(r_first_error), "first error overwritten")
    `HRL_ASSERT(a_write_in_store, o_push_a |-> 17'(r_running) < STORE_LIM && i_accept, "byte write outside store")

endmodule
`default_nettype wire

>>> design/hrl_outq.sv
`default_nettype none
`include "assert_macros.svh"
module hrl_outq
    import hrl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_result i_res_a,
    input  wire logic    i_push_a,
    input  wire t_result i_res_b,
    input  wire logic    i_push_b,
    input  wire logic    i_pop,
    output t_result      o_head,
    output logic         o_valid,
    output logic         o_full
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, n_wr;
    logic [Q_PTR_W-1:0]   r_rd, n_rd;
    logic [Q_CNT_W-1:0]   r_count, n_count;
    logic [Q_CNT_W-1:0]   push_n;
    logic                 pop;

    assign pop     = i_pop && (r_count != '0);
    assign push_n  = Q_CNT_W'(i_push_a) + Q_CNT_W'(i_push_b);
    assign n_wr    = r_wr + Q_PTR_W'(push_n);
    assign n_rd    = r_rd + Q_PTR_W'(pop);
    assign n_count = r_count + push_n - Q_CNT_W'(pop);

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    // room for two words is kept so an accepted character never overflows
    assign o_full  = (r_count > Q_CNT_W'(Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wr] <= i_res_a;
        end else if (i_push_b) begin
            r_mem[r_wr] <= i_res_b;
        end
        if (i_push_a && i_push_b) begin
            r_mem[r_wr + Q_PTR_W'(1)] <= i_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `HRL_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> r_count == '0, "queue not empty after reset")
    `HRL_ASSERT(a_no_overflow, (i_push_a || i_push_b) |-> r_count <= Q_CNT_W'(Q_DEPTH - 2), "push into full queue")

endmodule
`default_nettype wire

>>> design/hex_record_loader.sv
// hex_record_loader: parses hex-record text, one character per input word.
// input channel: i_valid / o_stall carrying i_char_in and i_last_char; a
// word is taken on a rising edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall carrying one result word: a byte write
// (o_result_kind 0) or the end-of-file summary (o_result_kind 1) with the
// image size and the first error seen; o_last_result marks the final word
// caused by one character.
// a result is written into a four-word result queue as its character is
// taken. throughput: one character per cycle while o_stall is low; the
// last character of a file can give two words, drained one per cycle
// while i_stall is low. o_stall rises once the queue holds more than two
// words, so a stalled receiver holds its word and input is then held off.
// reset (synchronous, i_rst_n low) empties the queue and returns the parser
// to the start of a line with no error; the summary also clears the parser
// so that a new file can follow straight away.
`default_nettype none
module hex_record_loader
    import hrl_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_last_char,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_result_kind,
    output logic [12:0]      o_write_address,
    output logic [7:0]       o_write_byte,
    output logic [16:0]      o_image_size,
    output logic [1:0]       o_error_code,
    output logic             o_last_result
);

    t_result res_a;
    t_result res_b;
    t_result head;
    logic    push_a;
    logic    push_b;
    logic    accept;

    assign accept = i_valid && !o_stall;

    hrl_parser #(
        .STORE_BYTES (STORE_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .o_res_a     (res_a),
        .o_push_a    (push_a),
        .o_res_b     (res_b),
        .o_push_b    (push_b)
    );

    hrl_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res_a  (res_a),
        .i_push_a (push_a),
        .i_res_b  (res_b),
        .i_push_b (push_b),
        .i_pop    (!i_stall),
        .o_head   (head),
        .o_valid  (o_valid),
        .o_full   (o_stall)
    );

    assign o_result_kind   = head.kind;
    assign o_write_address = head.wr_addr;
    assign o_write_byte    = head.wr_data;
    assign o_image_size    = head.img_size;
    assign o_error_code    = head.err;
    assign o_last_result   = head.last;

endmodule
`default_nettype wire

>>> sim/hex_record_loader_test.sv
`default_nettype none
module hex_record_loader_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hrl_pkg::*;

    localparam int STORE = STORE_BYTES_DEF;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_word;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_char_in = 8'h00;
    logic        i_last_char = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_result_kind;
    logic [12:0] o_write_address;
    logic [7:0]  o_write_byte;
    logic [16:0] o_image_size;
    logic [1:0]  o_error_code;
    logic        o_last_result;

    hex_record_loader dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_in       (i_char_in),
        .i_last_char     (i_last_char),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_kind   (o_result_kind),
        .o_write_address (o_write_address),
        .o_write_byte    (o_write_byte),
        .o_image_size    (o_image_size),
        .o_error_code    (o_error_code),
        .o_last_result   (o_last_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_text_word hex_text[$];
    logic [7:0] file_buf[$];
    t_result    expected_words[$];
    int         mismatch_count = 0;

    // parser state mirror
    logic [9:0]  line_pos;
    logic [7:0]  rec_count;
    logic [15:0] rec_start;
    logic [15:0] run_addr;
    logic [3:0]  hi_nib;
    logic [15:0] best_start;
    logic [7:0]  best_count;
    logic [1:0]  first_err;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c - CH_ZERO);
        if (c >= CH_UP_A && c <= CH_UP_A + 8'd5) return int'(c - CH_UP_A) + 10;
        if (c >= CH_LO_A && c <= CH_LO_A + 8'd5) return int'(c - CH_LO_A) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) return CH_ZERO + 8'(nib);
        return (upper ? CH_UP_A : CH_LO_A) + 8'(nib) - 8'd10;
    endfunction

    task automatic clear_parser();
        line_pos = POS_START;
        rec_count = '0;
        rec_start = '0;
        run_addr = '0;
        hi_nib = '0;
        best_start = '0;
        best_count = '0;
        first_err = ERR_NONE;
    endtask

    task automatic note_error(input logic [1:0] code);
        if (first_err == ERR_NONE) first_err = code;
        line_pos = POS_IGNORE;
    endtask

    task automatic decode_char(input logic [7:0] c, input logic last);
        t_result wr;
        t_result sm;
        bit      have_wr;
        int      d;
        int      k;
        logic [9:0] p;
        have_wr = 1'b0;
        p = line_pos;
        d = nibble_of(c);
        if (c == CH_NL) begin
            if (p == POS_START) note_error(ERR_COLON);
            line_pos = POS_START;
        end else if (p == POS_IGNORE) begin
            // skipping to end of line
        end else if (p == POS_START) begin
            if (c == CH_COLON) line_pos = 10'd1;
            else note_error(ERR_COLON);
        end else if (p < POS_DATA) begin
            if (d < 0) begin
                note_error(ERR_HEX);
            end else begin
                if (p <= 10'd2) rec_count = {rec_count[3:0], 4'(d)};
                else if (p <= 10'd6) rec_start = {rec_start[11:0], 4'(d)};
                if (p == 10'd8) begin
                    run_addr = rec_start;
                    if (rec_count != 8'd0 && rec_start >= best_start) begin
                        best_start = rec_start;
                        best_count = rec_count;
                    end
                end
                line_pos = p + 10'd1;
            end
        end else begin
            k = int'(p) - int'(POS_DATA);
            if (k < 2 * int'(rec_count)) begin
                if (d < 0) begin
                    note_error(ERR_HEX);
                end else if (k % 2 == 0) begin
                    hi_nib = 4'(d);
                    line_pos = p + 10'd1;
                end else if (int'(run_addr) >= STORE) begin
                    note_error(ERR_ADDR);
                end else begin
                    wr.kind = KIND_WRITE;
                    wr.wr_addr = run_addr[12:0];
                    wr.wr_data = {hi_nib, 4'(d)};
                    wr.img_size = '0;
                    wr.err = ERR_NONE;
                    wr.last = !last;
                    have_wr = 1'b1;
                    run_addr = run_addr + 16'd1;
                    line_pos = p + 10'd1;
                end
            end else begin
                line_pos = (p >= POS_LAST) ? POS_IGNORE : p + 10'd1;
            end
        end
        if (have_wr) expected_words.push_back(wr);
        if (last) begin
            sm.kind = KIND_SUMMARY;
            sm.wr_addr = '0;
            sm.wr_data = '0;
            sm.img_size = 17'(best_start) + 17'(best_count);
            sm.err = first_err;
            sm.last = 1'b1;
            expected_words.push_back(sm);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %0h expected %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_word();
        t_result want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, kind", o_result_kind, 0);
        end else begin
            want = expected_words.pop_front();
            if (o_result_kind !== want.kind)
                report_mismatch("result_kind", o_result_kind, want.kind);
            if (o_write_address !== want.wr_addr)
                report_mismatch("write_address", o_write_address, want.wr_addr);
            if (o_write_byte !== want.wr_data)
                report_mismatch("write_byte", o_write_byte, want.wr_data);
            if (o_image_size !== want.img_size)
                report_mismatch("image_size", o_image_size, want.img_size);
            if (o_error_code !== want.err)
                report_mismatch("error_code", o_error_code, want.err);
            if (o_last_result !== want.last)
                report_mismatch("last_result", o_last_result, want.last);
        end
    endtask

    // stimulus construction
    task automatic add_char(input logic [7:0] c, input logic last);
        t_text_word w;
        w.ch = c;
        w.last = last;
        hex_text.push_back(w);
    endtask

    task automatic add_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], last_at_end && i == s.len() - 1);
    endtask

    task automatic buf_hex(input logic [15:0] v, input int digits);
        for (int i = digits - 1; i >= 0; i--)
            file_buf.push_back(hex_digit(v[i*4 +: 4], 1'($urandom_range(0, 1))));
    endtask

    task automatic buf_junk(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(0, 255));
            file_buf.push_back(c == CH_NL ? CH_SPACE : c);
        end
    endtask

    logic [15:0] tie_start = '0;

    task automatic buf_record();
        int          cnt;
        int          shape;
        int          first;
        int          ndig;
        logic [15:0] start;
        first = file_buf.size();
        case ($urandom_range(0, 9))
            0: cnt = 0;
            9: cnt = $urandom_range(13, 40);
            default: cnt = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 9))
            6: start = 16'(STORE - $urandom_range(1, cnt + 1));
            7: start = 16'hFFF0 + 16'($urandom_range(0, 15));
            8: start = tie_start;
            9: start = 16'($urandom_range(0, 16'hFFFF));
            default: start = 16'($urandom_range(0, STORE - 1));
        endcase
        if (cnt > 0) tie_start = start;
        shape = $urandom_range(0, 9);
        file_buf.push_back(CH_COLON);
        buf_hex(16'(cnt), 2);
        buf_hex(start, 4);
        buf_hex(16'($urandom_range(0, 5)), 2);
        ndig = (shape == 7 && cnt > 0) ? $urandom_range(0, 2 * cnt - 1) : 2 * cnt;
        for (int i = 0; i < ndig; i++) buf_hex(16'($urandom_range(0, 15)), 1);
        if (shape != 7) buf_hex(16'($urandom_range(0, 255)), 2);
        if (shape == 8) buf_junk($urandom_range(1, 8));
        if (shape == 9) file_buf[$urandom_range(first, file_buf.size() - 1)] =
            8'($urandom_range(0, 255));
        file_buf.push_back(CH_NL);
    endtask

    task automatic buf_long_record();
        file_buf.push_back(CH_COLON);
        buf_hex(16'h00FF, 2);
        buf_hex(16'($urandom_range(0, 3000)), 4);
        buf_hex(16'h0000, 2);
        for (int i = 0; i < 255; i++) buf_hex(16'($urandom_range(0, 255)), 2);
        buf_junk(530);
        file_buf.push_back(CH_NL);
    endtask

    task automatic commit_file();
        if (file_buf.size() > 1 && $urandom_range(0, 6) == 0) void'(file_buf.pop_back());
        foreach (file_buf[i]) add_char(file_buf[i], i == file_buf.size() - 1);
        file_buf.delete();
    endtask

    task automatic build_stimulus();
        int file_no;
        int nlines;
        file_no = 0;
        // directed: lower case data at top of store, bad digit, empty line,
        // byte just past the store with summary, lone non-colon character
        add_text(":011FFF00fF\n", 1'b0);
        add_text(":0", 1'b0);
        add_char(8'h00, 1'b0);
        add_char(CH_NL, 1'b0);
        add_char(CH_NL, 1'b0);
        add_text(":012000007e", 1'b1);
        add_char(8'hFF, 1'b1);
        while (hex_text.size() < 1650) begin
            nlines = $urandom_range(1, 6);
            for (int l = 0; l < nlines; l++) begin
                if (file_no == 2 && l == 0) buf_long_record();
                case ($urandom_range(0, 9))
                    7: begin
                        buf_junk($urandom_range(0, 10));
                        file_buf.push_back(CH_NL);
                    end
                    8: begin
                        file_buf.push_back(CH_COLON);
                        for (int i = $urandom_range(0, 7); i > 0; i--)
                            buf_hex(16'($urandom_range(0, 15)), 1);
                        file_buf.push_back(CH_NL);
                    end
                    default: buf_record();
                endcase
            end
            commit_file();
            file_no++;
        end
    endtask

    // sender and receiver
    bit         in_taken = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    t_text_word next_word;
    t_rx_mode   rx_mode = RX_FREE;
    int         rx_left = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (hex_text.size() > 0) begin
                    next_word = hex_text.pop_front();
                    i_valid <= 1'b1;
                    i_char_in <= next_word.ch;
                    i_last_char <= next_word.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 256);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:  i_stall <= ((rx_left % 8) < 5);
        endcase
    end

    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) decode_char(i_char_in, i_last_char);
        if (i_rst_n && o_valid && !i_stall) check_word();
    end

    initial begin
        clear_parser();
        build_stimulus();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (hex_text.size() == 0 && !i_valid);
        wait (expected_words.size() == 0);
        repeat (16) @(posedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch("words never seen", expected_words.size(), 0);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
